// File: hw/rtl/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

	localparam int unsigned LINE_BYTES = 4096;
	localparam int unsigned MAX_SPANS  = 4;
	localparam int unsigned IDX_W      = $clog2(MAX_SPANS);
	localparam int unsigned CNT_W      = $clog2(MAX_SPANS + 1);
	// Line offsets run from 0 to LINE_BYTES; one more bit covers the offset
	// just past the line end.
	localparam int unsigned POS_W      = $clog2(LINE_BYTES + 1);
	localparam int unsigned EXT_W      = POS_W + 1;
	localparam int unsigned BEGIN_W    = 12;
	localparam int unsigned FINISH_W   = 13;
	localparam int unsigned NUM_KW     = 7;

	// Lexer modes
	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_WS    = 3'd1;
	localparam logic [2:0] M_IDENT = 3'd2;
	localparam logic [2:0] M_INT   = 3'd3;
	localparam logic [2:0] M_FRAC  = 3'd4;
	localparam logic [2:0] M_EXPE  = 3'd5;
	localparam logic [2:0] M_EXPS  = 3'd6;
	localparam logic [2:0] M_EXPD  = 3'd7;

	// Span classes
	localparam logic [2:0] C_DEF   = 3'd0;
	localparam logic [2:0] C_NUM   = 3'd1;
	localparam logic [2:0] C_OP    = 3'd2;
	localparam logic [2:0] C_PAREN = 3'd3;
	localparam logic [2:0] C_FUNC  = 3'd4;
	localparam logic [2:0] C_UNK   = 3'd5;

	localparam logic [31:0] KW_WORD [NUM_KW] = '{
		32'h0073696E, 32'h00636F73, 32'h0074616E, 32'h00007069,
		32'h00000065, 32'h71756974, 32'h68656C70
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd4, 3'd4
	};

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} lex_item_t;

	typedef struct packed {
		logic [2:0]          token_class;
		logic [BEGIN_W-1:0]  span_begin;
		logic [FINISH_W-1:0] span_finish;
		logic                final_span;
	} span_t;

	typedef struct packed {
		span_t [MAX_SPANS-1:0] spans;
		logic [CNT_W-1:0]      count;
	} span_set_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] pos;
		logic             digit_seen;
		logic [31:0]      prefix;
		logic [2:0]       icount;
		logic [15:0]      held;
		logic [1:0]       hcount;
	} lex_state_t;

	typedef struct packed {
		lex_state_t st;
		span_set_t  set;
	} lex_work_t;

	function automatic logic is_ws(logic [7:0] b);
		return b inside {[8'd9:8'd13], 8'd32};
	endfunction

	function automatic logic is_dig(logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_istart(logic [7:0] b);
		return b inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
	endfunction

	function automatic logic is_icont(logic [7:0] b);
		return is_istart(b) || is_dig(b);
	endfunction

	function automatic logic [2:0] kw_class(logic [31:0] prefix, logic [2:0] icount);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_KW; k++) begin
			if (icount == KW_LEN[k] && prefix == KW_WORD[k]) begin
				hit = 1'b1;
			end
		end
		return hit ? C_FUNC : C_UNK;
	endfunction

	function automatic lex_work_t ident_add(lex_work_t w, logic [7:0] b);
		lex_work_t r;
		r = w;
		if (w.st.icount < 3'd4) begin
			r.st.prefix = {w.st.prefix[23:0], b};
		end
		if (w.st.icount < 3'd5) begin
			r.st.icount = w.st.icount + 3'd1;
		end
		return r;
	endfunction

	// Appends one span with offsets clamped to the line size; spans beyond
	// the set's capacity are dropped.
	function automatic lex_work_t push_span(lex_work_t w, logic [2:0] cls,
			logic [EXT_W-1:0] b, logic [EXT_W-1:0] e);
		lex_work_t        r;
		logic [EXT_W-1:0] bc;
		logic [EXT_W-1:0] ec;
		r  = w;
		bc = (b > EXT_W'(LINE_BYTES - 1)) ? EXT_W'(LINE_BYTES - 1) : b;
		ec = (e > EXT_W'(LINE_BYTES)) ? EXT_W'(LINE_BYTES) : e;
		if (ec <= bc) begin
			ec = bc + EXT_W'(1);
		end
		if (w.set.count < CNT_W'(MAX_SPANS)) begin
			r.set.spans[w.set.count[IDX_W-1:0]] = '{
				token_class: cls,
				span_begin:  bc[BEGIN_W-1:0],
				span_finish: ec[FINISH_W-1:0],
				final_span:  1'b0
			};
			r.set.count = w.set.count + CNT_W'(1);
		end
		return r;
	endfunction

	function automatic lex_work_t close_open(lex_work_t w, logic [EXT_W-1:0] p);
		lex_work_t        r;
		logic [EXT_W-1:0] s;
		s = EXT_W'(w.st.start);
		case (w.st.mode)
			M_WS: r = push_span(w, C_DEF, s, p);
			M_IDENT: r = push_span(w, kw_class(w.st.prefix, w.st.icount), s, p);
			M_INT, M_EXPD: r = push_span(w, C_NUM, s, p);
			M_FRAC: r = push_span(w, w.st.digit_seen ? C_NUM : C_DEF, s, p);
			default: r = w;
		endcase
		r.st.mode = M_IDLE;
		return r;
	endfunction

	// The exponent failed: the number ends before the held 'e', which opens
	// an identifier; a held sign becomes an operator span.
	function automatic lex_work_t unwind(lex_work_t w, logic [EXT_W-1:0] p);
		lex_work_t        r;
		logic [1:0]       n;
		logic [EXT_W-1:0] epos;
		n    = w.st.hcount;
		epos = (p >= EXT_W'(n)) ? p - EXT_W'(n) : '0;
		r    = push_span(w, C_NUM, EXT_W'(w.st.start), epos);
		r.st.mode   = M_IDENT;
		r.st.start  = epos[POS_W-1:0];
		r.st.prefix = '0;
		r.st.icount = '0;
		r = ident_add(r, (n == 2'd2) ? w.st.held[15:8] : w.st.held[7:0]);
		if (n == 2'd2) begin
			r = push_span(r, kw_class(r.st.prefix, r.st.icount), epos, epos + EXT_W'(1));
			r = push_span(r, C_OP, epos + EXT_W'(1), epos + EXT_W'(2));
			r.st.mode = M_IDLE;
		end
		r.st.held   = '0;
		r.st.hcount = '0;
		return r;
	endfunction

	function automatic lex_work_t start_token(lex_work_t w, logic [7:0] b,
			logic [EXT_W-1:0] p);
		lex_work_t r;
		r = w;
		r.st.mode = M_IDLE;
		if (is_ws(b)) begin
			r.st.mode  = M_WS;
			r.st.start = p[POS_W-1:0];
		end else if (b inside {8'h28, 8'h29}) begin
			r = push_span(r, C_PAREN, p, p + EXT_W'(1));
		end else if (b inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E, 8'h2C}) begin
			r = push_span(r, C_OP, p, p + EXT_W'(1));
		end else if (is_dig(b)) begin
			r.st.mode       = M_INT;
			r.st.start      = p[POS_W-1:0];
			r.st.digit_seen = 1'b1;
		end else if (b == 8'h2E) begin
			r.st.mode       = M_FRAC;
			r.st.start      = p[POS_W-1:0];
			r.st.digit_seen = 1'b0;
		end else if (is_istart(b)) begin
			r.st.mode   = M_IDENT;
			r.st.start  = p[POS_W-1:0];
			r.st.prefix = '0;
			r.st.icount = '0;
			r = ident_add(r, b);
		end else begin
			r = push_span(r, C_DEF, p, p + EXT_W'(1));
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/clt_lex.sv
`timescale 1ns / 1ps

module clt_lex (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  clt_pkg::lex_item_t item,
	output clt_pkg::span_set_t set
);
	import clt_pkg::*;

	lex_state_t       state_q;
	lex_state_t       state_d;
	lex_work_t        w;
	logic             done;
	logic             is_e;
	logic [7:0]       b;
	logic [EXT_W-1:0] p;
	logic [EXT_W-1:0] pn;

	always_comb begin
		w.st  = state_q;
		w.set = '0;
		b     = item.char_code;
		p     = EXT_W'(state_q.pos);
		pn    = p + EXT_W'(1);
		is_e  = (b == 8'h65) || (b == 8'h45);
		done  = 1'b0;

		// Pending exponent: after the 'e' a sign or digit keeps it, after the sign only a digit; anything else unwinds.
		if (w.st.mode == M_EXPE) begin
			if (b == 8'h2B || b == 8'h2D) begin
				w.st.held   = {w.st.held[7:0], b};
				w.st.hcount = 2'd2;
				w.st.mode   = M_EXPS;
				done = 1'b1;
			end else if (is_dig(b)) begin
				w.st.mode   = M_EXPD;
				w.st.held   = '0;
				w.st.hcount = '0;
				done = 1'b1;
			end else begin
				w = unwind(w, p);
			end
		end else if (w.st.mode == M_EXPS) begin
			if (is_dig(b)) begin
				w.st.mode   = M_EXPD;
				w.st.held   = '0;
				w.st.hcount = '0;
				done = 1'b1;
			end else begin
				w = unwind(w, p);
			end
		end

		if (!done) begin
			case (w.st.mode)
				M_WS: begin
					done = is_ws(b);
				end
				M_IDENT: begin
					if (is_icont(b)) begin
						w = ident_add(w, b);
						done = 1'b1;
					end
				end
				M_INT: begin
					if (is_dig(b)) begin
						done = 1'b1;
					end else if (b == 8'h2E) begin
						w.st.mode = M_FRAC;
						done = 1'b1;
					end else if (is_e) begin
						w.st.mode   = M_EXPE;
						w.st.held   = {8'h00, b};
						w.st.hcount = 2'd1;
						done = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_dig(b)) begin
						w.st.digit_seen = 1'b1;
						done = 1'b1;
					end else if (w.st.digit_seen && is_e) begin
						w.st.mode   = M_EXPE;
						w.st.held   = {8'h00, b};
						w.st.hcount = 2'd1;
						done = 1'b1;
					end
				end
				M_EXPD: begin
					done = is_dig(b);
				end
				default: begin
					done = 1'b0;
				end
			endcase
		end

		if (!done) begin
			w = close_open(w, p);
			w = start_token(w, b, p);
		end

		if (item.line_end) begin
			if (w.st.mode == M_EXPE || w.st.mode == M_EXPS) begin
				w = unwind(w, pn);
			end
			w = close_open(w, pn);
			if (w.set.count != '0) begin
				w.set.spans[IDX_W'(w.set.count - CNT_W'(1))].final_span = 1'b1;
			end
			state_d = '0;
		end else begin
			state_d     = w.st;
			state_d.pos = (pn > EXT_W'(LINE_BYTES)) ? POS_W'(LINE_BYTES) : pn[POS_W-1:0];
		end

		set = w.set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_d;
		end
	end

endmodule

// File: hw/rtl/clt_span_buf.sv
`timescale 1ns / 1ps

module clt_span_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_valid,
	output logic               load_ready,
	input  clt_pkg::span_set_t load_set,
	output logic               span_valid,
	input  logic               span_ready,
	output clt_pkg::span_t     span_item
);
	import clt_pkg::*;

	span_set_t        set_q;
	logic [CNT_W-1:0] rem_q;
	logic [IDX_W-1:0] idx_q;
	logic             take;

	assign span_valid = (rem_q != '0);
	assign span_item  = set_q.spans[idx_q];
	assign take       = span_valid && span_ready;
	// A new set may replace this one once its last span is being transferred.
	assign load_ready = (rem_q == '0) || (rem_q == CNT_W'(1) && span_ready);

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			set_q <= load_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load_valid && load_ready) begin
			rem_q <= load_set.count;
			idx_q <= '0;
		end else if (take) begin
			rem_q <= rem_q - CNT_W'(1);
			idx_q <= idx_q + IDX_W'(1);
		end
	end

endmodule

// File: hw/rtl/calc_token_class_lexer.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake               Payload
// char      in   char_valid/char_ready   char_item: char_code, line_end
// span      out  span_valid/span_ready   span_item: token_class, span_begin,
//                                        span_finish, final_span
//
// A byte is registered on transfer and lexed from that register; its
// spans (up to four) are written into the span buffer as one set once the buffer can take them.
// The buffer sends one span per cycle while span_ready is high, and takes the
// next byte's set as the last span of the current one is transferred.
// Reset returns the lexer to the start of a line with no span pending.
// When the output stalls, the input register holds one byte and then
// char_ready falls.

module calc_token_class_lexer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_ready,
	input  clt_pkg::lex_item_t char_item,
	output logic               span_valid,
	input  logic               span_ready,
	output clt_pkg::span_t     span_item
);
	import clt_pkg::*;

	lex_item_t item_s1;
	logic      valid_s1;
	logic      load_ready;
	logic      adv;
	span_set_t set;

	assign adv        = valid_s1 && load_ready;
	assign char_ready = !valid_s1 || adv;

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			item_s1 <= char_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	clt_lex u_lex (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.set    (set)
	);

	clt_span_buf u_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (load_ready),
		.load_set   (set),
		.span_valid (span_valid),
		.span_ready (span_ready),
		.span_item  (span_item)
	);

endmodule

// File: dv/calc_token_class_lexer_tb.sv
`timescale 1ns / 1ps

module calc_token_class_lexer_tb;

	import clt_pkg::*;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_ready;
	lex_item_t  char_item  = '0;
	logic       span_valid;
	logic       span_ready = 1'b0;
	span_t      span_item;

	calc_token_class_lexer u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.span_valid (span_valid),
		.span_ready (span_ready),
		.span_item  (span_item)
	);

	always #5 clk = ~clk;

	// Lexer state mirrored for prediction.
	logic [2:0]  lx_mode;
	int          lx_start;
	int          lx_pos;
	logic        lx_digit;
	logic [31:0] lx_word;
	int          lx_len;
	logic [15:0] lx_held;
	int          lx_nheld;

	span_t       step_spans[$];
	span_t       line_spans[$];
	lex_item_t   byte_stream[$];
	logic [7:0]  text_buf[$];

	logic        char_fire  = 1'b0;
	logic        span_hold  = 1'b0;
	logic        idle_on    = 1'b1;
	logic        stall_on   = 1'b1;
	int          send_gap   = 0;
	int          send_burst = 0;
	int          stall_left = 0;
	int          stall_burst = 0;

	int          errors      = 0;
	int          bytes_in    = 0;
	int          spans_seen  = 0;
	int          lines_done  = 0;
	int          random_bytes = 0;
	int          longest_line = 0;

	function automatic logic ws_byte(logic [7:0] b);
		return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
	endfunction

	function automatic logic digit_byte(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic word_start(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic logic word_char(logic [7:0] b);
		return word_start(b) || digit_byte(b);
	endfunction

	function automatic void clear_lexer();
		lx_mode  = M_IDLE;
		lx_start = 0;
		lx_pos   = 0;
		lx_digit = 1'b0;
		lx_word  = '0;
		lx_len   = 0;
		lx_held  = '0;
		lx_nheld = 0;
	endfunction

	// Offsets are clamped to the line size and a span is never empty.
	function automatic void add_span(logic [2:0] cls, int b, int e);
		span_t s;
		if (step_spans.size() >= MAX_SPANS) return;
		if (b > int'(LINE_BYTES) - 1) b = int'(LINE_BYTES) - 1;
		if (e > int'(LINE_BYTES)) e = int'(LINE_BYTES);
		if (e <= b) e = b + 1;
		s.token_class = cls;
		s.span_begin  = b[BEGIN_W-1:0];
		s.span_finish = e[FINISH_W-1:0];
		s.final_span  = 1'b0;
		step_spans.push_back(s);
	endfunction

	function automatic logic [2:0] word_class();
		logic hit;
		case (lx_len)
			1: hit = (lx_word == "e");
			2: hit = (lx_word == "pi");
			3: hit = (lx_word == "sin") || (lx_word == "cos") || (lx_word == "tan");
			4: hit = (lx_word == "quit") || (lx_word == "help");
			default: hit = 1'b0;
		endcase
		return hit ? C_FUNC : C_UNK;
	endfunction

	function automatic void word_add(logic [7:0] b);
		if (lx_len < 4) lx_word = {lx_word[23:0], b};
		if (lx_len < 5) lx_len++;
	endfunction

	function automatic void close_span(int p);
		case (lx_mode)
			M_WS: add_span(C_DEF, lx_start, p);
			M_IDENT: add_span(word_class(), lx_start, p);
			M_INT, M_EXPD: add_span(C_NUM, lx_start, p);
			M_FRAC: add_span(lx_digit ? C_NUM : C_DEF, lx_start, p);
			default: ;
		endcase
		lx_mode = M_IDLE;
	endfunction

	// The exponent did not get a digit: the number stops before the 'e', which
	// becomes an identifier, and a held sign becomes an operator.
	function automatic void drop_exponent(int p);
		int epos;
		int n;
		n    = lx_nheld;
		epos = (p >= n) ? p - n : 0;
		add_span(C_NUM, lx_start, epos);
		lx_mode  = M_IDENT;
		lx_start = epos;
		lx_word  = '0;
		lx_len   = 0;
		word_add((n == 2) ? lx_held[15:8] : lx_held[7:0]);
		if (n == 2) begin
			add_span(word_class(), epos, epos + 1);
			add_span(C_OP, epos + 1, epos + 2);
			lx_mode = M_IDLE;
		end
		lx_held  = '0;
		lx_nheld = 0;
	endfunction

	function automatic void open_token(logic [7:0] b, int p);
		lx_mode = M_IDLE;
		if (ws_byte(b)) begin
			lx_mode  = M_WS;
			lx_start = p;
		end else if (b == "(" || b == ")") begin
			add_span(C_PAREN, p, p + 1);
		end else if (b == "+" || b == "-" || b == "*" || b == "/" || b == "^" || b == ",") begin
			add_span(C_OP, p, p + 1);
		end else if (digit_byte(b)) begin
			lx_mode  = M_INT;
			lx_start = p;
			lx_digit = 1'b1;
		end else if (b == ".") begin
			lx_mode  = M_FRAC;
			lx_start = p;
			lx_digit = 1'b0;
		end else if (word_start(b)) begin
			lx_mode  = M_IDENT;
			lx_start = p;
			lx_word  = '0;
			lx_len   = 0;
			word_add(b);
		end else begin
			add_span(C_DEF, p, p + 1);
		end
	endfunction

	function automatic void feed(logic [7:0] b, int p);
		logic is_e;
		is_e = (b == "e") || (b == "E");
		if (lx_mode == M_EXPE) begin
			if (b == "+" || b == "-") begin
				lx_held  = {lx_held[7:0], b};
				lx_nheld = 2;
				lx_mode  = M_EXPS;
				return;
			end
			if (digit_byte(b)) begin
				lx_mode  = M_EXPD;
				lx_held  = '0;
				lx_nheld = 0;
				return;
			end
			drop_exponent(p);
		end else if (lx_mode == M_EXPS) begin
			if (digit_byte(b)) begin
				lx_mode  = M_EXPD;
				lx_held  = '0;
				lx_nheld = 0;
				return;
			end
			drop_exponent(p);
		end
		case (lx_mode)
			M_WS: begin
				if (ws_byte(b)) return;
			end
			M_IDENT: begin
				if (word_char(b)) begin
					word_add(b);
					return;
				end
			end
			M_INT: begin
				if (digit_byte(b)) return;
				if (b == ".") begin
					lx_mode = M_FRAC;
					return;
				end
				if (is_e) begin
					lx_mode  = M_EXPE;
					lx_held  = {8'h00, b};
					lx_nheld = 1;
					return;
				end
			end
			M_FRAC: begin
				if (digit_byte(b)) begin
					lx_digit = 1'b1;
					return;
				end
				if (lx_digit && is_e) begin
					lx_mode  = M_EXPE;
					lx_held  = {8'h00, b};
					lx_nheld = 1;
					return;
				end
			end
			M_EXPD: begin
				if (digit_byte(b)) return;
			end
			default: ;
		endcase
		close_span(p);
		open_token(b, p);
	endfunction

	// Works out the spans that one byte releases and queues them.
	function automatic void lex_byte(logic [7:0] b, logic last);
		int    p;
		span_t s;
		p = lx_pos;
		step_spans.delete();
		feed(b, p);
		if (last) begin
			if (lx_mode == M_EXPE || lx_mode == M_EXPS) drop_exponent(p + 1);
			close_span(p + 1);
			if (step_spans.size() != 0) begin
				s = step_spans.pop_back();
				s.final_span = 1'b1;
				step_spans.push_back(s);
			end
			if (p + 1 > longest_line) longest_line = p + 1;
			clear_lexer();
			lines_done++;
		end else begin
			lx_pos = (p + 1 > int'(LINE_BYTES)) ? int'(LINE_BYTES) : p + 1;
		end
		foreach (step_spans[i]) line_spans.push_back(step_spans[i]);
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Sender: a byte is held until its transfer, then the next one follows
	// after a random gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
		end else if (char_valid && !char_fire) begin
			char_valid <= 1'b1;
		end else if (send_gap > 0) begin
			send_gap   <= send_gap - 1;
			char_valid <= 1'b0;
		end else if (byte_stream.size() != 0) begin
			char_item  <= byte_stream.pop_front();
			char_valid <= 1'b1;
			send_gap   <= idle_on ? pick_gap() : 0;
			if (send_burst == 0) begin
				send_burst <= $urandom_range(10, 60);
				idle_on    <= ($urandom_range(0, 2) != 0);
			end else begin
				send_burst <= send_burst - 1;
			end
		end else begin
			char_valid <= 1'b0;
		end
	end

	// Receiver: random stalls, switched off for whole stretches.
	always @(negedge clk) begin
		if (!arst_n || span_hold) begin
			span_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			span_ready <= 1'b0;
		end else begin
			span_ready <= 1'b1;
			if (stall_on && $urandom_range(0, 99) < 30) stall_left <= pick_gap();
			if (stall_burst == 0) begin
				stall_burst <= $urandom_range(20, 120);
				stall_on    <= ($urandom_range(0, 2) != 0);
			end else begin
				stall_burst <= stall_burst - 1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		span_t want;
		char_fire <= char_valid && char_ready;
		if (arst_n && char_valid && char_ready) begin
			lex_byte(char_item.char_code, char_item.line_end);
			bytes_in++;
		end
		if (arst_n && span_valid && span_ready) begin
			spans_seen++;
			if (line_spans.size() == 0) begin
				errors++;
				$display("%0t: extra span, expected none, got %0d [%0d,%0d) final %0b",
					$time, span_item.token_class, span_item.span_begin,
					span_item.span_finish, span_item.final_span);
			end else begin
				want = line_spans.pop_front();
				if (span_item.token_class !== want.token_class ||
						span_item.span_begin !== want.span_begin ||
						span_item.span_finish !== want.span_finish ||
						span_item.final_span !== want.final_span) begin
					errors++;
					$display("%0t: expected %0d [%0d,%0d) %0b, got %0d [%0d,%0d) %0b",
						$time, want.token_class, want.span_begin, want.span_finish,
						want.final_span, span_item.token_class, span_item.span_begin,
						span_item.span_finish, span_item.final_span);
				end
			end
		end
	end

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
	endtask

	task automatic send_line();
		lex_item_t it;
		foreach (text_buf[i]) begin
			it.char_code = text_buf[i];
			it.line_end  = (i == text_buf.size() - 1);
			byte_stream.push_back(it);
		end
		text_buf.delete();
	endtask

	function automatic logic [7:0] rand_word_char(logic first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26) return 8'(int'("a") + r);
		if (r < 52) return 8'(int'("A") + r - 26);
		if (r == 52) return "_";
		return 8'(int'("0") + r - 53);
	endfunction

	task automatic put_digits(int lo, int hi);
		repeat ($urandom_range(lo, hi)) text_buf.push_back(8'(int'("0") + $urandom_range(0, 9)));
	endtask

	task automatic put_keyword();
		case ($urandom_range(0, 6))
			0: put_text("sin");
			1: put_text("cos");
			2: put_text("tan");
			3: put_text("pi");
			4: put_text("e");
			5: put_text("quit");
			default: put_text("help");
		endcase
	endtask

	// Appends one token of random kind; neighbouring tokens may run together,
	// which the lexer must handle as well.
	task automatic put_token();
		string other;
		string ops;
		int    k;
		int    n;
		other = "!\"#$%&':;<=>?@[\\]`{|}~";
		ops   = "+-*/^,";
		k = $urandom_range(0, 19);
		if (k < 3) begin
			repeat ($urandom_range(1, 3)) begin
				n = $urandom_range(0, 5);
				text_buf.push_back((n == 5) ? 8'd32 : 8'(9 + n));
			end
		end else if (k == 3) begin
			text_buf.push_back($urandom_range(0, 1) ? "(" : ")");
		end else if (k < 6) begin
			text_buf.push_back(ops[$urandom_range(0, 5)]);
		end else if (k < 10) begin
			n = $urandom_range(0, 9);
			if (n < 7) put_digits(1, 4);
			if (n >= 5) begin
				text_buf.push_back(".");
				put_digits(0, 3);
			end
			if ($urandom_range(0, 1)) begin
				text_buf.push_back($urandom_range(0, 1) ? "e" : "E");
				if ($urandom_range(0, 1)) text_buf.push_back($urandom_range(0, 1) ? "+" : "-");
				put_digits(0, 2);
			end
		end else if (k < 12) begin
			put_keyword();
		end else if (k < 15) begin
			if ($urandom_range(0, 2) == 0) begin
				put_keyword();
				text_buf.push_back(rand_word_char(1'b0));
			end else begin
				text_buf.push_back(rand_word_char(1'b1));
				repeat ($urandom_range(0, 5)) text_buf.push_back(rand_word_char(1'b0));
			end
		end else if (k < 18) begin
			n = $urandom_range(0, 9);
			if (n == 0) text_buf.push_back(8'd0);
			else if (n < 3) text_buf.push_back(8'($urandom_range(128, 255)));
			else if (n == 3) text_buf.push_back($urandom_range(0, 1) ? 8'd127 : 8'($urandom_range(14, 31)));
			else text_buf.push_back(other[$urandom_range(0, other.len() - 1)]);
		end else begin
			text_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic wait_drained();
		while (byte_stream.size() != 0 || char_valid) @(posedge clk);
		while (line_spans.size() != 0) @(posedge clk);
	endtask

	initial begin
		clear_lexer();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Failed exponents with and without a sign, one cut short by the
		// line end, a fraction with exponent, a lone dot and the operators , * / ^.
		put_text("1e+x");
		send_line();
		put_text("2E");
		send_line();
		put_text(".5e3 .,*/^");
		send_line();
		text_buf = '{8'd0, 8'd255, "(", "e", ")", 8'd13, 8'd1};
		send_line();
		put_text("_");
		send_line();
		wait_drained();

		// Output held off while the input keeps coming, so the block backs up.
		repeat (6) put_text("(1e+x)*(2E-y)^sin,");
		send_line();
		@(posedge clk);
		span_hold <= 1'b1;
		repeat (150) @(posedge clk);
		span_hold <= 1'b0;

		while (random_bytes < 280) begin
			repeat ($urandom_range(1, 10)) put_token();
			random_bytes += text_buf.size();
			send_line();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("%0d bytes in %0d lines lexed, %0d spans checked, longest line %0d bytes",
			bytes_in, lines_done, spans_seen, longest_line);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
